@@ sv/svpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared widths, register map, reset values and payload types for the
// min-max zero-sequence SVPWM duty unit.
// ----------------------------------------------------------------------------
package svpwm_pkg;

	// Field and bus widths
	localparam int unsigned DATA_W = 16;
	localparam int unsigned APB_W  = 32;
	localparam int unsigned ADDR_W = 4;

	// Internal arithmetic widths
	localparam int unsigned PH_W  = 32;  // phase values, Q.30, |x| < 2^31
	localparam int unsigned SUM_W = 33;  // max + min
	localparam int unsigned D2_W  = 35;  // doubled duty, Q.31, signed
	localparam int unsigned DQ_W  = D2_W - 15;  // duty after dropping 15 bits

	// round(sqrt(3)/2 * 2^15)
	localparam logic [DATA_W-1:0] SQRT3_HALF_Q15 = 16'd28378;

	// One half in Q.31 doubled-duty scale
	localparam logic signed [D2_W-1:0] ONE_Q30 = D2_W'(64'sd1073741824);

	// Register map (index = paddr[ADDR_W-1:2])
	typedef logic [ADDR_W-3:0] reg_idx_t;
	localparam reg_idx_t REG_DUTY_MIN  = 2'd0;
	localparam reg_idx_t REG_DUTY_MAX  = 2'd1;
	localparam reg_idx_t REG_PWM_FULL  = 2'd2;

	// Register reset values
	localparam logic [DATA_W-1:0] DUTY_MIN_RST = 16'd0;
	localparam logic [DATA_W-1:0] DUTY_MAX_RST = 16'd65535;
	localparam logic [DATA_W-1:0] PWM_FULL_RST = 16'd4000;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [DATA_W-1:0] duty_min;
		logic [DATA_W-1:0] duty_max;
		logic [DATA_W-1:0] pwm_full_count;
	} cfg_t;

	// Three phase values from the inverse Clarke transform
	typedef struct packed {
		logic signed [PH_W-1:0] u;
		logic signed [PH_W-1:0] v;
		logic signed [PH_W-1:0] w;
	} phase_t;

	// Three clamped Q0.16 duties
	typedef struct packed {
		logic [DATA_W-1:0] u;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] w;
	} duty_t;

endpackage

@@ sv/svpwm_regs.sv @@
// ----------------------------------------------------------------------------
// svpwm_regs
// APB register file: duty window and PWM full count.
// ----------------------------------------------------------------------------
module svpwm_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [svpwm_pkg::ADDR_W-1:0]      paddr,
	input  logic [svpwm_pkg::APB_W-1:0]       pwdata,
	output logic [svpwm_pkg::APB_W-1:0]       prdata,
	output logic                              pready,
	output svpwm_pkg::cfg_t                   cfg
);

	logic                    wr_en;
	svpwm_pkg::reg_idx_t     idx;
	logic [svpwm_pkg::DATA_W-1:0] duty_min_q;
	logic [svpwm_pkg::DATA_W-1:0] duty_max_q;
	logic [svpwm_pkg::DATA_W-1:0] pwm_full_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[svpwm_pkg::ADDR_W-1:2];

	// Register writes; unmapped index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_min_q <= svpwm_pkg::DUTY_MIN_RST;
			duty_max_q <= svpwm_pkg::DUTY_MAX_RST;
			pwm_full_q <= svpwm_pkg::PWM_FULL_RST;
		end else if (wr_en) begin
			case (idx)
				svpwm_pkg::REG_DUTY_MIN: duty_min_q <= pwdata[svpwm_pkg::DATA_W-1:0];
				svpwm_pkg::REG_DUTY_MAX: duty_max_q <= pwdata[svpwm_pkg::DATA_W-1:0];
				svpwm_pkg::REG_PWM_FULL: pwm_full_q <= pwdata[svpwm_pkg::DATA_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			svpwm_pkg::REG_DUTY_MIN: prdata = svpwm_pkg::APB_W'(duty_min_q);
			svpwm_pkg::REG_DUTY_MAX: prdata = svpwm_pkg::APB_W'(duty_max_q);
			svpwm_pkg::REG_PWM_FULL: prdata = svpwm_pkg::APB_W'(pwm_full_q);
			default:                 prdata = '0;
		endcase
	end

	assign cfg.duty_min       = duty_min_q;
	assign cfg.duty_max       = duty_max_q;
	assign cfg.pwm_full_count = pwm_full_q;

endmodule

@@ sv/svpwm_clarke.sv @@
// ----------------------------------------------------------------------------
// svpwm_clarke
// Stage 1: inverse Clarke transform. Stage 2: max + min of the phases.
// ----------------------------------------------------------------------------
module svpwm_clarke (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [svpwm_pkg::DATA_W-1:0]    v_alpha,
	input  logic signed [svpwm_pkg::DATA_W-1:0]    v_beta,
	input  logic [svpwm_pkg::DATA_W-1:0]           bus_in,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output svpwm_pkg::phase_t                      ph_out,
	output logic signed [svpwm_pkg::SUM_W-1:0]     mm_sum_out,
	output logic [svpwm_pkg::DATA_W-1:0]           bus_out
);

	localparam int unsigned PW = svpwm_pkg::PH_W;

	logic                   stall_s1, stall_s2;
	logic                   valid_s1, valid_s2;
	logic signed [PW-1:0]   a_full, a_half, bk;
	logic signed [PW:0]     bk_full;
	svpwm_pkg::phase_t      ph_c;
	svpwm_pkg::phase_t      ph_s1, ph_s2;
	logic [svpwm_pkg::DATA_W-1:0] bus_s1, bus_s2;
	logic signed [PW-1:0]   max_uv, min_uv, ph_max, ph_min;
	logic signed [svpwm_pkg::SUM_W-1:0] mm_sum_s2;

	// Stall chain
	assign stall_s2 = valid_s2 && out_stall;
	assign stall_s1 = valid_s1 && stall_s2;
	assign in_stall = stall_s1;

	// Inverse Clarke: u = a*2^15, v,w = -a*2^14 +/- b*K
	assign a_full  = {v_alpha[15], v_alpha, 15'd0};
	assign a_half  = {{2{v_alpha[15]}}, v_alpha, 14'd0};
	assign bk_full = v_beta * $signed({1'b0, svpwm_pkg::SQRT3_HALF_Q15});
	assign bk      = bk_full[PW-1:0];
	assign ph_c.u  = a_full;
	assign ph_c.v  = bk - a_half;
	assign ph_c.w  = -a_half - bk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !stall_s1) begin
			ph_s1  <= ph_c;
			bus_s1 <= bus_in;
		end
	end

	// Max and min of the three phases
	assign max_uv = (ph_s1.v > ph_s1.u) ? ph_s1.v : ph_s1.u;
	assign min_uv = (ph_s1.v < ph_s1.u) ? ph_s1.v : ph_s1.u;
	assign ph_max = (ph_s1.w > max_uv) ? ph_s1.w : max_uv;
	assign ph_min = (ph_s1.w < min_uv) ? ph_s1.w : min_uv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && !stall_s2) begin
			ph_s2     <= ph_s1;
			bus_s2    <= bus_s1;
			mm_sum_s2 <= {ph_max[PW-1], ph_max} + {ph_min[PW-1], ph_min};
		end
	end

	assign out_valid  = valid_s2;
	assign ph_out     = ph_s2;
	assign mm_sum_out = mm_sum_s2;
	assign bus_out    = bus_s2;

	// Inverse Clarke output is balanced: u + v + w == 0
	a_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ({{2{ph_s1.u[PW-1]}}, ph_s1.u} + {{2{ph_s1.v[PW-1]}}, ph_s1.v}
			+ {{2{ph_s1.w[PW-1]}}, ph_s1.w}) == '0)
		else $error("phase sum not zero");

	// Stage 2 holds its request while stalled downstream
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall_s2 |=> valid_s2 && $stable(mm_sum_s2))
		else $error("stage 2 lost a stalled request");

endmodule

@@ sv/svpwm_duty.sv @@
// ----------------------------------------------------------------------------
// svpwm_duty
// Stage 3: zero-sequence injection, one-half offset, window clamp.
// ----------------------------------------------------------------------------
module svpwm_duty (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  svpwm_pkg::phase_t                      ph_in,
	input  logic signed [svpwm_pkg::SUM_W-1:0]     mm_sum_in,
	input  logic [svpwm_pkg::DATA_W-1:0]           bus_in,
	input  svpwm_pkg::cfg_t                        cfg,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output svpwm_pkg::duty_t                       duty_out,
	output logic [svpwm_pkg::DATA_W-1:0]           bus_out
);

	localparam int unsigned DW = svpwm_pkg::DATA_W;

	logic              stall_s3, valid_s3;
	svpwm_pkg::duty_t  duty_c, duty_s3;
	logic [DW-1:0]     bus_s3;

	// Doubled duty 2x - max - min + 2^30, floor by 2^15, clamp low then high
	function automatic logic [DW-1:0] phase_duty(
		input logic signed [svpwm_pkg::PH_W-1:0]  x,
		input logic signed [svpwm_pkg::SUM_W-1:0] s,
		input logic [DW-1:0]                      dmin,
		input logic [DW-1:0]                      dmax
	);
		logic signed [svpwm_pkg::D2_W-1:0] d2;
		logic signed [svpwm_pkg::DQ_W-1:0] dq, dl, lo, hi;
		d2 = $signed({{2{x[svpwm_pkg::PH_W-1]}}, x, 1'b0})
			- $signed({{2{s[svpwm_pkg::SUM_W-1]}}, s}) + svpwm_pkg::ONE_Q30;
		dq = d2[svpwm_pkg::D2_W-1:15];
		lo = $signed({{(svpwm_pkg::DQ_W-DW){1'b0}}, dmin});
		hi = $signed({{(svpwm_pkg::DQ_W-DW){1'b0}}, dmax});
		dl = (dq < lo) ? lo : dq;
		return (dl > hi) ? dmax : dl[DW-1:0];
	endfunction

	assign stall_s3 = valid_s3 && out_stall;
	assign in_stall = stall_s3;

	assign duty_c.u = phase_duty(ph_in.u, mm_sum_in, cfg.duty_min, cfg.duty_max);
	assign duty_c.v = phase_duty(ph_in.v, mm_sum_in, cfg.duty_min, cfg.duty_max);
	assign duty_c.w = phase_duty(ph_in.w, mm_sum_in, cfg.duty_min, cfg.duty_max);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (!stall_s3) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !stall_s3) begin
			duty_s3 <= duty_c;
			bus_s3  <= bus_in;
		end
	end

	assign out_valid = valid_s3;
	assign duty_out  = duty_s3;
	assign bus_out   = bus_s3;

	// Upper bound is applied last, so no duty exceeds duty_max
	a_duty_max: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (duty_s3.u <= cfg.duty_max) && (duty_s3.v <= cfg.duty_max)
			&& (duty_s3.w <= cfg.duty_max))
		else $error("duty above window");

	// With an ordered window no duty falls below duty_min
	a_duty_min: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (cfg.duty_min <= cfg.duty_max)) |->
			(duty_s3.u >= cfg.duty_min) && (duty_s3.v >= cfg.duty_min)
			&& (duty_s3.w >= cfg.duty_min))
		else $error("duty below window");

endmodule

@@ sv/svpwm_scale.sv @@
// ----------------------------------------------------------------------------
// svpwm_scale
// Stage 4: duty times full count and duty times bus voltage, floor by 2^16.
// ----------------------------------------------------------------------------
module svpwm_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  svpwm_pkg::duty_t              duty_in,
	input  logic [svpwm_pkg::DATA_W-1:0]  bus_in,
	input  svpwm_pkg::cfg_t               cfg,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [svpwm_pkg::DATA_W-1:0]  count_u,
	output logic [svpwm_pkg::DATA_W-1:0]  count_v,
	output logic [svpwm_pkg::DATA_W-1:0]  count_w,
	output logic [svpwm_pkg::DATA_W-1:0]  volt_u,
	output logic [svpwm_pkg::DATA_W-1:0]  volt_v,
	output logic [svpwm_pkg::DATA_W-1:0]  volt_w
);

	localparam int unsigned DW = svpwm_pkg::DATA_W;

	logic            stall_s4, valid_s4;
	logic [2*DW-1:0] pc_u, pc_v, pc_w, pv_u, pv_v, pv_w;
	logic [DW-1:0]   count_u_s4, count_v_s4, count_w_s4;
	logic [DW-1:0]   volt_u_s4, volt_v_s4, volt_w_s4;

	assign stall_s4 = valid_s4 && out_stall;
	assign in_stall = stall_s4;

	// Six independent 16x16 products
	assign pc_u = duty_in.u * cfg.pwm_full_count;
	assign pc_v = duty_in.v * cfg.pwm_full_count;
	assign pc_w = duty_in.w * cfg.pwm_full_count;
	assign pv_u = duty_in.u * bus_in;
	assign pv_v = duty_in.v * bus_in;
	assign pv_w = duty_in.w * bus_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (!stall_s4) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !stall_s4) begin
			count_u_s4 <= pc_u[2*DW-1:DW];
			count_v_s4 <= pc_v[2*DW-1:DW];
			count_w_s4 <= pc_w[2*DW-1:DW];
			volt_u_s4  <= pv_u[2*DW-1:DW];
			volt_v_s4  <= pv_v[2*DW-1:DW];
			volt_w_s4  <= pv_w[2*DW-1:DW];
		end
	end

	assign out_valid = valid_s4;
	assign count_u   = count_u_s4;
	assign count_v   = count_v_s4;
	assign count_w   = count_w_s4;
	assign volt_u    = volt_u_s4;
	assign volt_v    = volt_v_s4;
	assign volt_w    = volt_w_s4;

	// A duty below one gives a count below the full count
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && (cfg.pwm_full_count != '0)) |->
			(count_u_s4 < cfg.pwm_full_count) && (count_v_s4 < cfg.pwm_full_count)
			&& (count_w_s4 < cfg.pwm_full_count))
		else $error("compare count out of range");

endmodule

@@ sv/svpwm_min_max_duty_unit.sv @@
// ----------------------------------------------------------------------------
// svpwm_min_max_duty_unit
// SVPWM duty generator with min-max zero-sequence injection: inverse Clarke,
// midpoint removal, one-half offset, window clamp, count and voltage scaling.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  input    | in_valid / in_stall        | v_alpha, v_beta, bus_voltage
//  output   | out_valid / out_stall      | count_u/v/w, volt_u/v/w
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
//  Four register stages (Clarke, max/min, duty clamp, scaling): a request
//  passes through them in that order, one request per cycle sustained
//  while out_stall is low.
//  Reset clears the stage valid bits and loads the register reset values.
//  out_stall holds the last stage; stalls move back stage by stage, so empty
//  stages still fill, and in_stall rises only when every stage is occupied.
// ----------------------------------------------------------------------------
module svpwm_min_max_duty_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [svpwm_pkg::ADDR_W-1:0]           paddr,
	input  logic [svpwm_pkg::APB_W-1:0]            pwdata,
	output logic [svpwm_pkg::APB_W-1:0]            prdata,
	output logic                                   pready,
	// Input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [svpwm_pkg::DATA_W-1:0]    v_alpha,
	input  logic signed [svpwm_pkg::DATA_W-1:0]    v_beta,
	input  logic [svpwm_pkg::DATA_W-1:0]           bus_voltage,
	// Output channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [svpwm_pkg::DATA_W-1:0]           count_u,
	output logic [svpwm_pkg::DATA_W-1:0]           count_v,
	output logic [svpwm_pkg::DATA_W-1:0]           count_w,
	output logic [svpwm_pkg::DATA_W-1:0]           volt_u,
	output logic [svpwm_pkg::DATA_W-1:0]           volt_v,
	output logic [svpwm_pkg::DATA_W-1:0]           volt_w
);

	svpwm_pkg::cfg_t                       cfg;
	svpwm_pkg::phase_t                     ph;
	svpwm_pkg::duty_t                      duty;
	logic signed [svpwm_pkg::SUM_W-1:0]    mm_sum;
	logic [svpwm_pkg::DATA_W-1:0]          bus_a, bus_b;
	logic                                  valid_a, stall_a, valid_b, stall_b;

	// Register file
	svpwm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stages 1-2: phases and max + min
	svpwm_clarke u_clarke (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.v_alpha    (v_alpha),
		.v_beta     (v_beta),
		.bus_in     (bus_voltage),
		.out_valid  (valid_a),
		.out_stall  (stall_a),
		.ph_out     (ph),
		.mm_sum_out (mm_sum),
		.bus_out    (bus_a)
	);

	// Stage 3: duties
	svpwm_duty u_duty (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_a),
		.in_stall  (stall_a),
		.ph_in     (ph),
		.mm_sum_in (mm_sum),
		.bus_in    (bus_a),
		.cfg       (cfg),
		.out_valid (valid_b),
		.out_stall (stall_b),
		.duty_out  (duty),
		.bus_out   (bus_b)
	);

	// Stage 4: counts and voltages
	svpwm_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_b),
		.in_stall  (stall_b),
		.duty_in   (duty),
		.bus_in    (bus_b),
		.cfg       (cfg),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.count_u   (count_u),
		.count_v   (count_v),
		.count_w   (count_w),
		.volt_u    (volt_u),
		.volt_v    (volt_v),
		.volt_w    (volt_w)
	);

	// Input backs up only behind a stalled, occupied output
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

endmodule
